/* rtl/core/fdl_pkg.sv */
`timescale 1ns / 1ps
package fdl_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int STEP_W    = 21;
  localparam int POS_W     = 28;
  localparam int FRAC_W    = 16;
  localparam int IPART_W   = POS_W - FRAC_W;
  localparam int LEN_W     = 13;
  localparam int MAX_LEN   = 4096;
  localparam int LEN_RESET = 4096;
  localparam int COEF_FRAC = 24;
  localparam int WORK_FRAC = 32;
  localparam int COEF_W    = 28;
  localparam int ACC_W     = COEF_W + SAMPLE_W + 3;

  localparam longint SAT_MAX = 64'sd8388607;
  localparam longint SAT_MIN = -64'sd8388608;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

/* rtl/core/fdl_store.sv */
`timescale 1ns / 1ps
module fdl_store
  import fdl_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/fdl_coef_rom.sv */
`timescale 1ns / 1ps
module fdl_coef_rom
  import fdl_pkg::*;
#(
  parameter int INTERP_ORDER = 4,
  parameter int INTERP_RES   = 256
) (
  input  logic                              clk,
  input  logic                              row_load,
  input  logic [$clog2(INTERP_RES)-1:0]     row,
  input  logic [$clog2(INTERP_ORDER)-1:0]   tap,
  output logic signed [COEF_W-1:0]          coef
);

  // Lagrange basis weight of tap j at row q, magnitude carried with WORK_FRAC bits
  function automatic logic signed [COEF_W-1:0] coef_calc(input int q, input int j);
    longint unsigned mag;
    longint          t;
    longint          gap;
    logic            neg;
    int              dm;
    mag = 64'd1 << WORK_FRAC;
    neg = 1'b0;
    for (int m = 0; m < INTERP_ORDER; m++) begin
      if (m != j) begin
        dm   = m + 1 - INTERP_ORDER / 2;
        t    = longint'(q) - longint'(INTERP_RES) * longint'(dm);
        gap  = longint'(j - m);
        if (t < 0) begin
          neg = !neg;
          t   = -t;
        end
        if (gap < 0) begin
          neg = !neg;
          gap = -gap;
        end
        // floor(floor(a / R) / d) equals floor(a / (R * d))
        mag = mag * 64'(t);
        mag = mag / INTERP_RES;
        case (gap)
          1: mag = mag / 1;
          2: mag = mag / 2;
          3: mag = mag / 3;
          4: mag = mag / 4;
          5: mag = mag / 5;
          6: mag = mag / 6;
          default: mag = mag / 7;
        endcase
      end
    end
    mag = (mag + (64'd1 << (WORK_FRAC - COEF_FRAC - 1))) >> (WORK_FRAC - COEF_FRAC);
    return neg ? -COEF_W'(mag) : COEF_W'(mag);
  endfunction

  logic signed [COEF_W-1:0] coef_table [INTERP_RES][INTERP_ORDER];
  logic signed [COEF_W-1:0] row_reg [INTERP_ORDER];

  for (genvar gq = 0; gq < INTERP_RES; gq++) begin : g_row
    for (genvar gj = 0; gj < INTERP_ORDER; gj++) begin : g_col
      assign coef_table[gq][gj] = coef_calc(gq, gj);
    end
  end

  always_ff @(posedge clk) begin
    if (row_load) begin
      row_reg <= coef_table[row];
    end
  end

  assign coef = row_reg[tap];

endmodule

/* rtl/core/fdl_mac.sv */
`timescale 1ns / 1ps
module fdl_mac
  import fdl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       busy,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int PROD_W = COEF_W + SAMPLE_W;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [ACC_W:0]    shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod <= coef * sample;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up at the coefficient point, then saturate
  always_comb begin
    rnd     = $signed({acc[ACC_W-1], acc}) +
              $signed((ACC_W + 1)'(64'd1 << (COEF_FRAC - 1)));
    shifted = rnd >>> COEF_FRAC;
    if (shifted > $signed((ACC_W + 1)'(SAT_MAX))) begin
      result = SAMPLE_W'(SAT_MAX);
    end else if (shifted < $signed((ACC_W + 1)'(SAT_MIN))) begin
      result = SAMPLE_W'(SAT_MIN);
    end else begin
      result = shifted[SAMPLE_W-1:0];
    end
  end

  assign busy = prod_valid;

endmodule

/* rtl/core/fdl_rem.sv */
`timescale 1ns / 1ps
module fdl_rem
  import fdl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LEN_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             busy,
  output logic [LEN_W-1:0] remainder
);

  localparam int CNT_W = $clog2(LEN_W);

  logic [LEN_W-1:0] quo_sh;
  logic [LEN_W-1:0] divisor_r;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] rem_next;
  logic [LEN_W:0]   trial;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    trial = {rem, quo_sh[LEN_W-1]};
    if (trial >= {1'b0, divisor_r}) begin
      rem_next = LEN_W'(trial - {1'b0, divisor_r});
    end else begin
      rem_next = LEN_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(LEN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh    <= dividend;
      divisor_r <= divisor;
      rem       <= '0;
    end else if (busy) begin
      quo_sh <= quo_sh << 1;
      rem    <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

/* rtl/core/fractional_delay_line_lagrange_unit.sv */
`timescale 1ns / 1ps
// Channel   Signals                                                 Direction
// config    cfg_write, cfg_data (delay_length)                      in
// item      item_valid/item_stall, sample_in, read_step,            in
//           load_read, read_load_value
// result    result_valid/result_stall, sample_out                   out
//
// After reset the delay store is zeroed, one entry a cycle, with item_stall high.
// Config writes are taken at any time. For an item, one store read port serves one
// tap a cycle, then multiply and accumulate drain. When the write pointer lies at or
// beyond a shortened length, a 13-step remainder unit sets the time instead.
// The result register frees the input side; a held result only stalls the next finish.
module fractional_delay_line_lagrange_unit
  import fdl_pkg::*;
#(
  parameter int BUFFER_DEPTH = 4096,
  parameter int INTERP_ORDER = 4,
  parameter int INTERP_RES   = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [LEN_W-1:0]           cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic signed [STEP_W-1:0]   read_step,
  input  logic                       load_read,
  input  logic [POS_W-1:0]           read_load_value,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
  localparam int CAP     = BUFFER_DEPTH < MAX_LEN ? BUFFER_DEPTH : MAX_LEN;
  localparam int PTR_W   = ADDR_W < IPART_W ? ADDR_W : IPART_W;
  localparam int TAP_W   = $clog2(INTERP_ORDER);
  localparam int ROW_W   = $clog2(INTERP_RES);
  localparam int IDX_W   = (ADDR_W > IPART_W ? ADDR_W : IPART_W) + 2;
  localparam int TAP_OFF = 1 - INTERP_ORDER / 2;
  localparam int LIM_W   = LEN_W + FRAC_W;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t                     state;
  logic [LEN_W-1:0]           delay_length;
  logic [PTR_W-1:0]           write_pointer;
  logic [POS_W-1:0]           read_position;
  logic [ADDR_W-1:0]          clear_addr;
  logic [TAP_W-1:0]           tap_cnt;
  logic [TAP_W-1:0]           tap_d;
  logic                       rd_pending;
  logic                       wrap_slow;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [STEP_W-1:0]   step_r;

  logic [LEN_W-1:0]           len;
  logic [LIM_W-1:0]           limit;
  logic                       accept;
  logic                       finish;
  logic                       out_free;
  logic [PTR_W:0]             wp_inc;
  logic                       need_mod;
  logic [IPART_W-1:0]         ipart;
  logic [FRAC_W+ROW_W:0]      row_prod;
  logic [ROW_W-1:0]           row;
  logic signed [IDX_W-1:0]    tap_sum;
  logic signed [IDX_W-1:0]    tap_wrap;
  logic signed [POS_W+1:0]    pos_sum;
  logic [POS_W-1:0]           pos_next;
  logic [PTR_W-1:0]           wp_next;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic signed [SAMPLE_W-1:0] mem_rdata;
  logic signed [COEF_W-1:0]   coef;
  mac_ctrl_t                  mac_ctrl;
  logic                       mac_busy;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic                       rem_busy;
  logic [LEN_W-1:0]           rem_value;

  always_comb begin
    if (delay_length == '0) begin
      len = LEN_W'(1);
    end else if (delay_length > LEN_W'(CAP)) begin
      len = LEN_W'(CAP);
    end else begin
      len = delay_length;
    end
  end

  assign limit      = {len, {FRAC_W{1'b0}}};
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;
  assign finish     = (state == ST_DRAIN) && !rd_pending && !mac_busy && !rem_busy &&
                      out_free;

  assign wp_inc   = {1'b0, write_pointer} + (PTR_W + 1)'(1);
  assign need_mod = LEN_W'(wp_inc) > len;

  // row of the coefficient table from the top fraction bits
  assign ipart    = read_position[POS_W-1:FRAC_W];
  assign row_prod = (FRAC_W + ROW_W + 1)'(read_position[FRAC_W-1:0]) *
                    (FRAC_W + ROW_W + 1)'(INTERP_RES);
  assign row      = row_prod[FRAC_W +: ROW_W];

  always_comb begin
    tap_sum = $signed(IDX_W'(ipart)) + $signed(IDX_W'(tap_cnt)) + $signed(IDX_W'(TAP_OFF));
    if (tap_sum < 0) begin
      tap_wrap = tap_sum + $signed(IDX_W'(BUFFER_DEPTH));
    end else if (tap_sum >= $signed(IDX_W'(BUFFER_DEPTH))) begin
      tap_wrap = tap_sum - $signed(IDX_W'(BUFFER_DEPTH));
    end else begin
      tap_wrap = tap_sum;
    end
  end

  always_comb begin
    pos_sum = $signed({2'b00, read_position}) + $signed((POS_W + 2)'(step_r));
    if (pos_sum < 0 || pos_sum >= $signed({1'b0, limit})) begin
      pos_next = '0;
    end else begin
      pos_next = pos_sum[POS_W-1:0];
    end
  end

  always_comb begin
    if (wrap_slow) begin
      wp_next = PTR_W'(rem_value);
    end else if (LEN_W'(wp_inc) == len) begin
      wp_next = '0;
    end else begin
      wp_next = wp_inc[PTR_W-1:0];
    end
  end

  // the sample write lands only after all tap reads, so no forwarding is needed
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clear_addr;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (finish) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(write_pointer);
      mem_wdata = sample_r;
    end
  end

  assign mem_re        = (state == ST_RUN);
  assign mac_ctrl.clear = accept;
  assign mac_ctrl.en    = rd_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      delay_length  <= LEN_W'(LEN_RESET);
      write_pointer <= '0;
      read_position <= '0;
      clear_addr    <= '0;
      tap_cnt       <= '0;
      rd_pending    <= 1'b0;
      wrap_slow     <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        delay_length <= cfg_data;
      end
      rd_pending <= mem_re;
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + ADDR_W'(1);
          if (clear_addr == ADDR_W'(BUFFER_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (load_read) begin
              read_position <= (LIM_W'(read_load_value) >= limit) ? '0 : read_load_value;
            end
            wrap_slow <= need_mod;
            tap_cnt   <= '0;
            state     <= ST_RUN;
          end
        end
        ST_RUN: begin
          tap_cnt <= tap_cnt + TAP_W'(1);
          if (tap_cnt == TAP_W'(INTERP_ORDER - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            result_valid  <= 1'b1;
            write_pointer <= wp_next;
            read_position <= pos_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= sample_in;
      step_r   <= read_step;
    end
    if (mem_re) begin
      tap_d <= tap_cnt;
    end
    if (finish) begin
      sample_out <= mac_result;
    end
  end

  fdl_store #(
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (tap_wrap[ADDR_W-1:0]),
    .rdata (mem_rdata)
  );

  fdl_coef_rom #(
    .INTERP_ORDER (INTERP_ORDER),
    .INTERP_RES   (INTERP_RES)
  ) u_coef_rom (
    .clk      (clk),
    .row_load (mem_re && (tap_cnt == '0)),
    .row      (row),
    .tap      (tap_d),
    .coef     (coef)
  );

  fdl_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef),
    .sample (mem_rdata),
    .busy   (mac_busy),
    .result (mac_result)
  );

  fdl_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && need_mod),
    .dividend  (LEN_W'(wp_inc)),
    .divisor   (len),
    .busy      (rem_busy),
    .remainder (rem_value)
  );

  // no sample write may disturb the tap reads
  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !mem_we)
    else $error("store written while taps are read");

  a_wp_in_range: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(write_pointer) < LEN_W'(CAP))
    else $error("write pointer beyond capacity");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (tap_cnt == '0))
    else $error("accepted transaction did not start tap reads");

  a_result_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DRAIN) && !$past(rem_busy))
    else $error("result raised outside finish");

endmodule
